### rtl/hbe_pkg.sv
// ----------------------------------------------------------------------------
// hbe_pkg
// Shared constants and types for the HTTP body extractor.
// ----------------------------------------------------------------------------
package hbe_pkg;

  // Default counter width for chunk size and byte count
  localparam int COUNT_WIDTH_DEF = 32;

  // APB register map: register i at byte address 4*i
  localparam int APB_ADDR_W = 3;
  localparam int APB_DATA_W = 32;
  localparam int CFG_LENGTH_W = 32;

  localparam logic REG_BODY_MODE      = 1'b0;
  localparam logic REG_CONTENT_LENGTH = 1'b1;

  // Body framing modes
  localparam logic [1:0] MODE_NONE        = 2'd0;
  localparam logic [1:0] MODE_CHUNKED     = 2'd1;
  localparam logic [1:0] MODE_FIXED       = 2'd2;
  localparam logic [1:0] MODE_UNTIL_CLOSE = 2'd3;

  // Chunked parser phases
  localparam int PHASE_W = 3;
  localparam logic [PHASE_W-1:0] PH_SIZE    = 3'd0;
  localparam logic [PHASE_W-1:0] PH_EXT     = 3'd1;
  localparam logic [PHASE_W-1:0] PH_SIZE_LF = 3'd2;
  localparam logic [PHASE_W-1:0] PH_DATA    = 3'd3;
  localparam logic [PHASE_W-1:0] PH_DATA_CR = 3'd4;
  localparam logic [PHASE_W-1:0] PH_DATA_LF = 3'd5;
  localparam logic [PHASE_W-1:0] PH_LAST_CR = 3'd6;
  localparam logic [PHASE_W-1:0] PH_LAST_LF = 3'd7;

  // Characters
  localparam logic [7:0] CH_CR = 8'h0d;
  localparam logic [7:0] CH_LF = 8'h0a;
  localparam int HEX_DIGIT_W = 4;

  // Outcome of one byte in the chunk parser
  typedef struct packed {
    logic [PHASE_W-1:0] phase;
    logic               payload;
    logic               done;
    logic               error;
  } chunk_step_t;

  // Hex digit decode: is_hex plus value
  function automatic logic [HEX_DIGIT_W:0] hex_decode(input logic [7:0] c);
    logic [HEX_DIGIT_W:0] r;
    r = '0;
    if (c >= "0" && c <= "9") begin
      r = {1'b1, 4'(c - "0")};
    end else if (c >= "a" && c <= "f") begin
      r = {1'b1, 4'(c - "a" + 8'd10)};
    end else if (c >= "A" && c <= "F") begin
      r = {1'b1, 4'(c - "A" + 8'd10)};
    end
    return r;
  endfunction

endpackage

### rtl/hbe_if.sv
// ----------------------------------------------------------------------------
// hbe stream interfaces
// Valid/ready channels for raw body bytes and extracted results.
// ----------------------------------------------------------------------------
interface hbe_raw_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       end_of_stream;

  modport source(output valid, in_byte, end_of_stream, input ready);
  modport sink(input valid, in_byte, end_of_stream, output ready);
endinterface

interface hbe_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] payload_byte;
  logic       payload_valid;
  logic       body_done;
  logic       framing_error;

  modport source(output valid, payload_byte, payload_valid, body_done, framing_error,
                 input ready);
  modport sink(input valid, payload_byte, payload_valid, body_done, framing_error,
               output ready);
endinterface

### rtl/hbe_chunk_parser.sv
// ----------------------------------------------------------------------------
// hbe_chunk_parser
// Next-state logic of the chunked transfer decoder for one byte.
// ----------------------------------------------------------------------------
module hbe_chunk_parser import hbe_pkg::*; #(
  parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
  input  logic [PHASE_W-1:0]     phase,
  input  logic [COUNT_WIDTH-1:0] remaining,
  input  logic [7:0]             in_byte,
  output chunk_step_t            step,
  output logic [COUNT_WIDTH-1:0] remaining_next
);

  logic [HEX_DIGIT_W:0]   hex;
  logic [COUNT_WIDTH-1:0] remaining_dec;
  logic                   size_full;

  assign hex           = hex_decode(in_byte);
  assign remaining_dec = remaining - 1'b1;
  // another digit would push bits out the top
  assign size_full     = |remaining[COUNT_WIDTH-1 -: HEX_DIGIT_W];

  always_comb begin
    step           = '{phase: phase, payload: 1'b0, done: 1'b0, error: 1'b0};
    remaining_next = remaining;
    unique case (phase)
      PH_SIZE: begin
        if (hex[HEX_DIGIT_W]) begin
          if (size_full) begin
            step.error = 1'b1;
          end else begin
            remaining_next = {remaining[COUNT_WIDTH-HEX_DIGIT_W-1:0], hex[HEX_DIGIT_W-1:0]};
          end
        end else if (in_byte == CH_CR) begin
          step.phase = PH_SIZE_LF;
        end else if (in_byte == CH_LF) begin
          step.error = 1'b1;
        end else begin
          step.phase = PH_EXT;
        end
      end
      // extension: skip up to CR
      PH_EXT: begin
        if (in_byte == CH_CR) begin
          step.phase = PH_SIZE_LF;
        end else if (in_byte == CH_LF) begin
          step.error = 1'b1;
        end
      end
      PH_SIZE_LF: begin
        if (in_byte != CH_LF) begin
          step.error = 1'b1;
        end else if (remaining == '0) begin
          step.phase = PH_LAST_CR;
        end else begin
          step.phase = PH_DATA;
        end
      end
      PH_DATA: begin
        step.payload   = 1'b1;
        remaining_next = remaining_dec;
        if (remaining_dec == '0) begin
          step.phase = PH_DATA_CR;
        end
      end
      PH_DATA_CR: begin
        if (in_byte == CH_CR) step.phase = PH_DATA_LF;
        else step.error = 1'b1;
      end
      PH_DATA_LF: begin
        if (in_byte == CH_LF) begin
          step.phase     = PH_SIZE;
          remaining_next = '0;
        end else begin
          step.error = 1'b1;
        end
      end
      PH_LAST_CR: begin
        if (in_byte == CH_CR) step.phase = PH_LAST_LF;
        else step.error = 1'b1;
      end
      PH_LAST_LF: begin
        if (in_byte == CH_LF) step.done = 1'b1;
        else step.error = 1'b1;
      end
      default: begin
        step.error = 1'b1;
      end
    endcase
  end

endmodule

### rtl/http_body_extractor_core.sv
// ----------------------------------------------------------------------------
// http_body_extractor_core
// Extracts payload bytes from an HTTP body: no body, chunked, fixed length
// or read until close, selected by an APB register.
// ----------------------------------------------------------------------------
//   channel     dir  transaction
//   raw         in   in_byte, end_of_stream
//   extracted   out  payload_byte, payload_valid, body_done, framing_error
//   apb         cfg  body_mode @0x0, content_length @0x4
//
// One result per byte, one byte per cycle; the parse state updates in the
// same cycle the byte is taken and the result lands in one output register.
// raw.ready stays high while the output register is empty or being drained,
// so once extracted.ready returns, a waiting byte is taken in that same cycle.
// Synchronous reset clears the parse state, flags, registers and output valid.
// ----------------------------------------------------------------------------
module http_body_extractor_core import hbe_pkg::*; #(
  parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready,
  hbe_raw_if.sink               raw,
  hbe_out_if.source             extracted
);

  localparam int CMP_W = (COUNT_WIDTH > CFG_LENGTH_W) ? COUNT_WIDTH : CFG_LENGTH_W;

  // configuration
  logic [1:0]              body_mode;
  logic [CFG_LENGTH_W-1:0] content_length;

  // parse state
  logic [PHASE_W-1:0]     parse_phase, parse_phase_next;
  logic [COUNT_WIDTH-1:0] chunk_remaining, chunk_remaining_next;
  logic [COUNT_WIDTH-1:0] bytes_received, bytes_received_next;
  logic                   done_flag, done_flag_next;
  logic                   error_flag, error_flag_next;
  logic                   emit_valid;

  // output register
  logic       out_valid;
  logic [7:0] out_byte;
  logic       out_payload_valid;

  logic                   accept;
  logic                   cfg_write;
  chunk_step_t            chunk_step;
  logic [COUNT_WIDTH-1:0] chunk_remaining_step;
  logic [COUNT_WIDTH-1:0] bytes_inc;
  logic                   fixed_reached, fixed_reached_inc;

  // APB register file
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      body_mode      <= MODE_NONE;
      content_length <= '0;
    end else if (cfg_write) begin
      unique case (paddr[APB_ADDR_W-1])
        REG_BODY_MODE:      body_mode      <= pwdata[1:0];
        REG_CONTENT_LENGTH: content_length <= pwdata[CFG_LENGTH_W-1:0];
        default:            body_mode      <= body_mode;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[APB_ADDR_W-1])
      REG_BODY_MODE:      prdata = APB_DATA_W'(body_mode);
      REG_CONTENT_LENGTH: prdata = APB_DATA_W'(content_length);
      default:            prdata = '0;
    endcase
  end

  // handshake: a new byte enters whenever the output register can take a result
  assign raw.ready = !out_valid || extracted.ready;
  assign accept    = raw.valid && raw.ready;

  hbe_chunk_parser #(
    .COUNT_WIDTH(COUNT_WIDTH)
  ) u_chunk (
    .phase         (parse_phase),
    .remaining     (chunk_remaining),
    .in_byte       (raw.in_byte),
    .step          (chunk_step),
    .remaining_next(chunk_remaining_step)
  );

  // fixed length: saturating count and compares against content_length
  assign bytes_inc         = (&bytes_received) ? bytes_received : bytes_received + 1'b1;
  assign fixed_reached     = CMP_W'(bytes_received) >= CMP_W'(content_length);
  assign fixed_reached_inc = CMP_W'(bytes_inc) >= CMP_W'(content_length);

  // next state for one byte
  always_comb begin
    parse_phase_next     = parse_phase;
    chunk_remaining_next = chunk_remaining;
    bytes_received_next  = bytes_received;
    done_flag_next       = done_flag;
    error_flag_next      = error_flag;
    emit_valid           = 1'b0;
    if (!done_flag && !error_flag) begin
      priority if (body_mode == MODE_NONE) begin
        done_flag_next = 1'b1;
      end else if (raw.end_of_stream) begin
        done_flag_next = 1'b1;
      end else begin
        unique case (body_mode)
          MODE_CHUNKED: begin
            parse_phase_next     = chunk_step.phase;
            chunk_remaining_next = chunk_remaining_step;
            emit_valid           = chunk_step.payload;
            done_flag_next       = chunk_step.done;
            error_flag_next      = chunk_step.error;
          end
          MODE_FIXED: begin
            if (fixed_reached) begin
              done_flag_next = 1'b1;
            end else begin
              emit_valid          = 1'b1;
              bytes_received_next = bytes_inc;
              done_flag_next      = fixed_reached_inc;
            end
          end
          MODE_UNTIL_CLOSE: emit_valid = 1'b1;
          default:          done_flag_next = 1'b1;
        endcase
      end
    end
  end

  // state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      parse_phase     <= PH_SIZE;
      chunk_remaining <= '0;
      bytes_received  <= '0;
      done_flag       <= 1'b0;
      error_flag      <= 1'b0;
    end else if (accept) begin
      parse_phase     <= parse_phase_next;
      chunk_remaining <= chunk_remaining_next;
      bytes_received  <= bytes_received_next;
      done_flag       <= done_flag_next;
      error_flag      <= error_flag_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept) begin
      out_valid <= 1'b1;
    end else if (extracted.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_byte          <= emit_valid ? raw.in_byte : 8'h00;
      out_payload_valid <= emit_valid;
    end
  end

  assign extracted.valid         = out_valid;
  assign extracted.payload_byte  = out_byte;
  assign extracted.payload_valid = out_payload_valid;
  assign extracted.body_done     = done_flag;
  assign extracted.framing_error = error_flag;

  // checks
  a_error_sticky: assert property (@(posedge clk) disable iff (rst)
    error_flag |=> error_flag)
    else $error("framing error flag cleared without reset");

  a_done_sticky: assert property (@(posedge clk) disable iff (rst)
    done_flag |=> done_flag)
    else $error("body done flag cleared without reset");

  a_no_payload_on_error: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(out_payload_valid && error_flag))
    else $error("payload byte delivered with framing error");

  a_state_holds_idle: assert property (@(posedge clk) disable iff (rst)
    !accept |=> $stable(parse_phase) && $stable(chunk_remaining) && $stable(bytes_received))
    else $error("parse state changed without a transaction");

  a_zero_when_not_payload: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_payload_valid) |-> (out_byte == 8'h00))
    else $error("non-payload result carries a byte");

endmodule
